[rtl/core/crb_pkg.sv]
// Shared types and constants for the circle raster bouncer.
// Used by every module under rtl/core but crb_checker; depends on nothing else.
package crb_pkg;

	// Register file geometry.
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Register indexes, in address order (byte address is four times the index).
	typedef enum logic [2:0] {
		REG_LEFT   = 3'd0,
		REG_TOP    = 3'd1,
		REG_WIDTH  = 3'd2,
		REG_HEIGHT = 3'd3,
		REG_RADIUS = 3'd4,
		REG_STARTX = 3'd5,
		REG_STARTY = 3'd6
	} crb_reg_e;

	// Register reset values.
	localparam logic [11:0] LEFT_RST   = 12'd0;
	localparam logic [11:0] TOP_RST    = 12'd0;
	localparam logic [12:0] WIDTH_RST  = 13'd640;
	localparam logic [12:0] HEIGHT_RST = 13'd480;
	localparam logic [9:0]  RADIUS_RST = 10'd32;
	localparam logic [12:0] STARTX_RST = 13'd320;
	localparam logic [12:0] STARTY_RST = 13'd240;

	// Default start velocity per axis.
	localparam int START_VEL_X_DEF = 2;
	localparam int START_VEL_Y_DEF = 2;

	// Midpoint decision variable constants.
	localparam logic [15:0] DEC_INIT      = 16'd3;
	localparam logic [15:0] DEC_STEP_DIAG = 16'd10;
	localparam logic [15:0] DEC_STEP_AXIS = 16'd6;

	// Pixels produced for one tick: eight before the step, eight after.
	localparam int PIX_PER_TICK = 16;
	localparam int PIX_CNT_W    = 4;

	// Stream word widths.
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 96;

	// Configuration seen by the datapath, plus start-position load strobes.
	typedef struct packed {
		logic [11:0] left;
		logic [11:0] top;
		logic [12:0] width;
		logic [12:0] height;
		logic [9:0]  radius;
		logic [12:0] start_x;
		logic [12:0] start_y;
		logic        ld_x;
		logic        ld_y;
	} crb_cfg_t;

	// One pixel on its way down the address pipeline.
	typedef struct packed {
		logic signed [14:0] x;
		logic signed [14:0] y;
		logic [31:0]        base;
		logic [31:0]        color;
		logic               item_last;
		logic               frame_last;
	} crb_pix_t;

endpackage

[rtl/core/crb_regs.sv]
// APB-style configuration register file for the circle raster bouncer.
// Depends on crb_pkg for register indexes, reset values and the config struct.
module crb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [crb_pkg::PADDR_W-1:0]  paddr,
	input  logic [crb_pkg::PDATA_W-1:0]  pwdata,
	output logic [crb_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output crb_pkg::crb_cfg_t            cfg
);
	import crb_pkg::*;

	logic [11:0] left_q;
	logic [11:0] top_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [9:0]  radius_q;
	logic [12:0] start_x_q;
	logic [12:0] start_y_q;
	logic        wr;
	crb_reg_e    idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = crb_reg_e'(paddr[PADDR_W-1:2]);

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= LEFT_RST;
			top_q     <= TOP_RST;
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			radius_q  <= RADIUS_RST;
			start_x_q <= STARTX_RST;
			start_y_q <= STARTY_RST;
		end else if (wr) begin
			case (idx)
				REG_LEFT:   left_q    <= pwdata[11:0];
				REG_TOP:    top_q     <= pwdata[11:0];
				REG_WIDTH:  width_q   <= pwdata[12:0];
				REG_HEIGHT: height_q  <= pwdata[12:0];
				REG_RADIUS: radius_q  <= pwdata[9:0];
				REG_STARTX: start_x_q <= pwdata[12:0];
				REG_STARTY: start_y_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (idx)
			REG_LEFT:   prdata = {20'd0, left_q};
			REG_TOP:    prdata = {20'd0, top_q};
			REG_WIDTH:  prdata = {19'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			REG_RADIUS: prdata = {22'd0, radius_q};
			REG_STARTX: prdata = {19'd0, start_x_q};
			REG_STARTY: prdata = {19'd0, start_y_q};
			default:    prdata = '0;
		endcase
	end

	// A start-position write also moves the center at once.
	always_comb begin
		cfg.left    = left_q;
		cfg.top     = top_q;
		cfg.width   = width_q;
		cfg.height  = height_q;
		cfg.radius  = radius_q;
		cfg.start_x = pwdata[12:0];
		cfg.start_y = pwdata[12:0];
		cfg.ld_x    = wr && (idx == REG_STARTX);
		cfg.ld_y    = wr && (idx == REG_STARTY);
	end

endmodule

[rtl/core/crb_tick.sv]
// Tick stage: frame start with bounce, one midpoint-circle step, and the
// tick register that hands out the sixteen symmetric pixels. Uses crb_pkg.
module crb_tick #(
	parameter int START_VEL_X = crb_pkg::START_VEL_X_DEF,
	parameter int START_VEL_Y = crb_pkg::START_VEL_Y_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  crb_pkg::crb_cfg_t  cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        frame_base,
	input  logic [31:0]        new_color,
	input  logic               adv,
	output logic               pix_valid,
	output crb_pkg::crb_pix_t  pix
);
	import crb_pkg::*;

	// Architectural state.
	logic signed [13:0] cx_q, cy_q;
	logic signed [7:0]  vx_q, vy_q;
	logic [31:0]        color_q, base_q;
	logic signed [10:0] ox_q, oy_q;
	logic [15:0]        dec_q;
	logic               active_q;

	// Tick register.
	logic                 valid_s1;
	logic [PIX_CNT_W-1:0] cnt_s1;
	logic signed [13:0]   cx_s1, cy_s1;
	logic signed [10:0]   xa_s1, ya_s1, xb_s1, yb_s1;
	logic [31:0]          color_s1, base_s1;
	logic                 fend_s1;

	logic               accept, emit, cnt_last;
	logic signed [14:0] nx, ny;
	logic signed [16:0] nx17, ny17, xhi, xlo, yhi, ylo;
	logic               hit_x, hit_y;
	logic signed [13:0] cx_n, cy_n;
	logic signed [7:0]  vx_n, vy_n;
	logic [31:0]        color_n, base_n;
	logic signed [10:0] x0, y0, x1, y1;
	logic [15:0]        d0, d1, diff16;
	logic signed [11:0] x1w, y1w;
	logic               dpos, fend;
	logic signed [10:0] u, v, su, sv;
	logic signed [14:0] px, py;

	assign cnt_last = (cnt_s1 == PIX_CNT_W'(PIX_PER_TICK - 1));
	assign emit     = valid_s1 && adv;
	assign in_ready = !valid_s1 || (adv && cnt_last);
	assign accept   = in_valid && in_ready;

	// Frame start: move the center, or bounce off a region edge.
	always_comb begin
		nx   = {cx_q[13], cx_q} + {{7{vx_q[7]}}, vx_q};
		ny   = {cy_q[13], cy_q} + {{7{vy_q[7]}}, vy_q};
		nx17 = {{2{nx[14]}}, nx};
		ny17 = {{2{ny[14]}}, ny};
		xhi  = $signed({5'd0, cfg.left}) + $signed({4'd0, cfg.width})
			- $signed({7'd0, cfg.radius});
		xlo  = $signed({5'd0, cfg.left}) + $signed({7'd0, cfg.radius});
		yhi  = $signed({5'd0, cfg.top}) + $signed({4'd0, cfg.height})
			- $signed({7'd0, cfg.radius});
		ylo  = $signed({5'd0, cfg.top}) + $signed({7'd0, cfg.radius});
		hit_x = (xhi < nx17) || (xlo > nx17);
		hit_y = (yhi < ny17) || (ylo > ny17);

		cx_n    = cx_q;
		cy_n    = cy_q;
		vx_n    = vx_q;
		vy_n    = vy_q;
		color_n = color_q;
		base_n  = base_q;
		x0      = ox_q;
		y0      = oy_q;
		d0      = dec_q;
		if (!active_q) begin
			base_n = frame_base;
			if (hit_x) begin
				vx_n    = -vx_q;
				color_n = new_color;
			end else if (hit_y) begin
				vy_n    = -vy_q;
				color_n = new_color;
			end else begin
				cx_n = nx[13:0];
				cy_n = ny[13:0];
			end
			x0 = '0;
			y0 = $signed({1'b0, cfg.radius});
			d0 = DEC_INIT - {5'd0, cfg.radius, 1'b0};
		end
	end

	// One midpoint step; x and y are kept one bit wider until stored.
	always_comb begin
		dpos   = !d0[15] && (d0 != '0);
		x1w    = {x0[10], x0} + 12'sd1;
		y1w    = dpos ? ({y0[10], y0} - 12'sd1) : {y0[10], y0};
		diff16 = {{4{x1w[11]}}, x1w} - {{4{y1w[11]}}, y1w};
		if (dpos) begin
			d1 = d0 + {diff16[13:0], 2'b00} + DEC_STEP_DIAG;
		end else begin
			d1 = d0 + {x1w[11], x1w[11], x1w, 2'b00} + DEC_STEP_AXIS;
		end
		x1   = x1w[10:0];
		y1   = y1w[10:0];
		fend = (y1 < x1);
	end

	// State update on each accepted tick, and center loads on start-position writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= $signed({1'b0, STARTX_RST});
			cy_q     <= $signed({1'b0, STARTY_RST});
			vx_q     <= 8'(START_VEL_X);
			vy_q     <= 8'(START_VEL_Y);
			color_q  <= '0;
			base_q   <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
		end else begin
			if (accept) begin
				cx_q     <= cx_n;
				cy_q     <= cy_n;
				vx_q     <= vx_n;
				vy_q     <= vy_n;
				color_q  <= color_n;
				base_q   <= base_n;
				ox_q     <= x1;
				oy_q     <= y1;
				dec_q    <= d1;
				active_q <= !fend;
			end
			if (cfg.ld_x) begin
				cx_q <= $signed({1'b0, cfg.start_x});
			end
			if (cfg.ld_y) begin
				cy_q <= $signed({1'b0, cfg.start_y});
			end
		end
	end

	// Tick register control: valid flag and pixel counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s1   <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			cnt_s1   <= '0;
		end else if (emit) begin
			cnt_s1 <= cnt_s1 + 1'b1;
			if (cnt_last) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Tick register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_s1    <= cx_n;
			cy_s1    <= cy_n;
			xa_s1    <= x0;
			ya_s1    <= y0;
			xb_s1    <= x1;
			yb_s1    <= y1;
			color_s1 <= color_n;
			base_s1  <= base_n;
			fend_s1  <= fend;
		end
	end

	// Eight-way symmetry: bit 3 picks the point, bit 2 swaps the axes,
	// bit 0 negates the x offset and bit 1 the y offset.
	always_comb begin
		u  = cnt_s1[3] ? xb_s1 : xa_s1;
		v  = cnt_s1[3] ? yb_s1 : ya_s1;
		su = cnt_s1[2] ? v : u;
		sv = cnt_s1[2] ? u : v;
		px = cnt_s1[0] ? ({cx_s1[13], cx_s1} - {{4{su[10]}}, su})
			: ({cx_s1[13], cx_s1} + {{4{su[10]}}, su});
		py = cnt_s1[1] ? ({cy_s1[13], cy_s1} - {{4{sv[10]}}, sv})
			: ({cy_s1[13], cy_s1} + {{4{sv[10]}}, sv});
	end

	assign pix_valid      = valid_s1;
	assign pix.x          = px;
	assign pix.y          = py;
	assign pix.base       = base_s1;
	assign pix.color      = color_s1;
	assign pix.item_last  = cnt_last;
	assign pix.frame_last = cnt_last && fend_s1;

endmodule

[rtl/core/crb_pixel.sv]
// Pixel address pipeline: row multiply, then base plus offset into the
// output register. Uses crb_pkg for the pixel struct.
module crb_pixel (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [12:0]        width,
	input  logic               pix_valid,
	input  crb_pkg::crb_pix_t  pix,
	output logic               adv,
	output logic               out_valid,
	input  logic               out_ready,
	output crb_pkg::crb_pix_t  out_pix,
	output logic [31:0]        out_address
);
	import crb_pkg::*;

	logic               valid_s2, valid_s3, valid_q;
	crb_pix_t           pix_s2, pix_s3, pix_q;
	logic signed [28:0] prod;
	logic [31:0]        prod_s3, off;
	logic [31:0]        addr_q;

	// The whole pipeline moves when the output register is free or taken.
	assign adv  = !valid_q || out_ready;
	assign prod = $signed({1'b0, width}) * pix_s2.y;
	assign off  = prod_s3 + {{17{pix_s3.x[14]}}, pix_s3.x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s2 <= pix_valid;
			valid_s3 <= valid_s2;
			valid_q  <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s2  <= pix;
			pix_s3  <= pix_s2;
			prod_s3 <= {{3{prod[28]}}, prod};
			pix_q   <= pix_s3;
			addr_q  <= pix_s3.base + {off[29:0], 2'b00};
		end
	end

	assign out_valid   = valid_q;
	assign out_pix     = pix_q;
	assign out_address = addr_q;

endmodule

[rtl/core/circle_raster_bouncer_unit.sv]
// Circle raster bouncer, top level: configuration registers, tick stage and
// pixel address pipeline. Depends on crb_pkg, crb_regs, crb_tick, crb_pixel.
//
// Each accepted input word is one tick and yields sixteen pixel words, one per
// cycle while the output is not back-pressured; the single-word-wide output
// stream sets that rate. The next tick is accepted in the same cycle
// that the previous tick's sixteenth pixel leaves the tick register, and a
// pixel then passes through the s2, s3 and output registers of crb_pixel.
// Back-pressure on the output stalls the whole pipeline. The first tick with
// no frame in progress starts a frame: it moves the center or bounces off the
// region edges, and latches frame_base. Writes to start_x and start_y move the
// center at once. Configuration must only be written while the block is idle.
module circle_raster_bouncer_unit #(
	parameter int START_VEL_X = crb_pkg::START_VEL_X_DEF,
	parameter int START_VEL_Y = crb_pkg::START_VEL_Y_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] frame_base, [63:32] new_color
	input  logic [crb_pkg::S_TDATA_W-1:0]  s_tdata,
	// Pixel stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [14:0] pixel_x, [29:15] pixel_y, [61:30] pixel_address,
	// [93:62] pixel_color, [95:94] zero
	output logic [crb_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast,
	// [0] frame_last
	output logic                           m_tuser,
	// Configuration port.
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [crb_pkg::PADDR_W-1:0]    paddr,
	input  logic [crb_pkg::PDATA_W-1:0]    pwdata,
	output logic [crb_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);
	import crb_pkg::*;

	crb_cfg_t    cfg;
	logic        adv, pix_valid;
	crb_pix_t    pix, out_pix;
	logic [31:0] out_address;

	crb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crb_tick #(
		.START_VEL_X (START_VEL_X),
		.START_VEL_Y (START_VEL_Y)
	) u_tick (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.frame_base (s_tdata[31:0]),
		.new_color  (s_tdata[63:32]),
		.adv        (adv),
		.pix_valid  (pix_valid),
		.pix        (pix)
	);

	crb_pixel u_pixel (
		.clk         (clk),
		.arst_n      (arst_n),
		.width       (cfg.width),
		.pix_valid   (pix_valid),
		.pix         (pix),
		.adv         (adv),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_pix     (out_pix),
		.out_address (out_address)
	);

	// Pack the pixel word.
	assign m_tdata = {2'b00, out_pix.color, out_address, out_pix.y, out_pix.x};
	assign m_tlast = out_pix.item_last;
	assign m_tuser = out_pix.frame_last;

endmodule

[rtl/core/crb_checker.sv]
// Port-level checks for the circle raster bouncer, bound to the top level.
// Depends only on the top level's port list.
module crb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser,
	input logic        pready
);

	logic [3:0] beat_q;

	// Count pixel words within a tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else if (m_tvalid && m_tready) begin
			beat_q <= m_tlast ? 4'd0 : beat_q + 4'd1;
		end
	end

	// A stalled pixel word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("pixel word changed while stalled");

	// The end of a frame is always the end of a tick.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end without tick end");

	// Every tick delivers exactly sixteen pixels.
	a_sixteen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> (m_tlast == (beat_q == 4'd15)))
		else $error("tick end not on the sixteenth pixel");

	// The register port never waits.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind circle_raster_bouncer_unit crb_checker u_crb_checker (.*);
